// File: rtl/core/rdcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcf_pkg
// Shared constants and types of the repeating decimal cycle finder.
// ----------------------------------------------------------------------------
package rdcf_pkg;

    localparam int MAX_DENOMINATOR = 64;
    localparam int BASE            = 10;

    localparam int NUM_W = 6;
    localparam int DEN_W = 7;
    localparam int DIG_W = 4;
    localparam int LEN_W = 6;

    localparam int REM_W = $clog2(MAX_DENOMINATOR);
    localparam int POS_W = REM_W + 1;
    localparam int XW    = REM_W + 4;
    localparam int CW    = DEN_W + 4;
    localparam int QW    = 2;

    typedef struct packed {
        logic             clear;
        logic [REM_W-1:0] rem_addr;
        logic             pos_we;
        logic [POS_W-1:0] pos_wdata;
        logic             dig_we;
        logic [REM_W-1:0] dig_waddr;
        logic [DIG_W-1:0] dig_wdata;
        logic [REM_W-1:0] dig_raddr;
    } t_tbl_req;

endpackage

// File: rtl/core/repeating_decimal_cycle_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_decimal_cycle_finder
// Long division of a proper fraction in base 10, finds the repeating cycle
// and emits its digits, one result word per cycle.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Out-of-range operands
// give one error word in the next cycle and busy stays low. Otherwise each
// division digit takes a seen-table lookup, then two radix-4 steps of the
// digit unit. A fraction that repeats after P digits with cycle length L
// holds busy until it has emitted its L words on consecutive cycles; a
// terminating fraction with P digits gives one word. The seen flags are
// cleared when a word is taken, so there is no clearing pass. Result words
// are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module repeating_decimal_cycle_finder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rdcf_pkg::NUM_W-1:0]    i_numerator,
    input  logic [rdcf_pkg::DEN_W-1:0]    i_denominator,
    output logic                          o_strobe,
    output logic [rdcf_pkg::DIG_W-1:0]    o_digit,
    output logic [rdcf_pkg::LEN_W-1:0]    o_cycle_length,
    output logic [rdcf_pkg::LEN_W-1:0]    o_cycle_start,
    output logic                          o_digit_valid,
    output logic                          o_is_last,
    output logic                          o_error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DIV,
        S_HIT,
        S_EMIT
    } t_state;

    t_state                        r_state, n_state;
    logic [rdcf_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [rdcf_pkg::DEN_W-1:0]    r_den, n_den;
    logic [rdcf_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [rdcf_pkg::POS_W-1:0]    r_start, n_start;
    logic [rdcf_pkg::POS_W-1:0]    r_len, n_len;
    logic [rdcf_pkg::POS_W-1:0]    r_idx, n_idx;
    logic                          r_strobe, n_strobe;
    logic [rdcf_pkg::DIG_W-1:0]    r_digit, n_digit;
    logic [rdcf_pkg::LEN_W-1:0]    r_olen, n_olen;
    logic [rdcf_pkg::LEN_W-1:0]    r_ostart, n_ostart;
    logic                          r_dvalid, n_dvalid;
    logic                          r_last, n_last;
    logic                          r_error, n_error;

    rdcf_pkg::t_tbl_req            req;
    logic                          seen;
    logic [rdcf_pkg::POS_W-1:0]    pos_rdata;
    logic [rdcf_pkg::DIG_W-1:0]    dig_rdata;
    logic                          div_start;
    logic                          div_done;
    logic [rdcf_pkg::DIG_W-1:0]    div_digit;
    logic [rdcf_pkg::REM_W-1:0]    div_rem;
    logic                          bad_op;
    logic [rdcf_pkg::POS_W-1:0]    hit_len;
    logic                          emit_last;

    rdcf_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_seen      (seen),
        .o_pos_rdata (pos_rdata),
        .o_dig_rdata (dig_rdata)
    );

    rdcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (r_rem),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_digit (div_digit),
        .o_rem   (div_rem)
    );

    always_comb begin
        bad_op = (i_denominator == '0)
              || (i_denominator > rdcf_pkg::DEN_W'(rdcf_pkg::MAX_DENOMINATOR))
              || ({1'b0, i_numerator} >= i_denominator);
        hit_len   = r_pos - pos_rdata;
        emit_last = (r_idx + rdcf_pkg::POS_W'(1)) == r_len;

        n_state  = r_state;
        n_rem    = r_rem;
        n_den    = r_den;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_digit  = '0;
        n_olen   = '0;
        n_ostart = '0;
        n_dvalid = 1'b0;
        n_last   = 1'b0;
        n_error  = 1'b0;

        div_start     = 1'b0;
        req           = '0;
        req.rem_addr  = r_rem;
        req.pos_wdata = r_pos;
        req.dig_waddr = r_pos[rdcf_pkg::REM_W-1:0];
        req.dig_wdata = div_digit;
        req.dig_raddr = rdcf_pkg::REM_W'(r_start + r_idx + rdcf_pkg::POS_W'(1));

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (bad_op) begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        n_error  = 1'b1;
                    end else begin
                        req.clear = 1'b1;
                        n_rem     = rdcf_pkg::REM_W'(i_numerator);
                        n_den     = i_denominator;
                        n_pos     = '0;
                        n_state   = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_rem == '0
                    || r_pos >= rdcf_pkg::POS_W'(rdcf_pkg::MAX_DENOMINATOR)) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else if (seen) begin
                    n_state = S_HIT;
                end else begin
                    req.pos_we = 1'b1;
                    div_start  = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    req.dig_we = 1'b1;
                    n_rem      = div_rem;
                    n_pos      = r_pos + rdcf_pkg::POS_W'(1);
                    n_state    = S_LOOK;
                end
            end
            S_HIT: begin
                if (hit_len == '0) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_start       = pos_rdata;
                    n_len         = hit_len;
                    n_idx         = '0;
                    req.dig_raddr = pos_rdata[rdcf_pkg::REM_W-1:0];
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_digit  = dig_rdata;
                n_olen   = r_len[rdcf_pkg::LEN_W-1:0];
                n_ostart = r_start[rdcf_pkg::LEN_W-1:0];
                n_dvalid = 1'b1;
                n_last   = emit_last;
                n_idx    = r_idx + rdcf_pkg::POS_W'(1);
                if (emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_rem    <= '0;
            r_pos    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_rem    <= n_rem;
            r_pos    <= n_pos;
        end
        r_den    <= n_den;
        r_start  <= n_start;
        r_len    <= n_len;
        r_idx    <= n_idx;
        r_digit  <= n_digit;
        r_olen   <= n_olen;
        r_ostart <= n_ostart;
        r_dvalid <= n_dvalid;
        r_last   <= n_last;
        r_error  <= n_error;
    end

    assign busy           = r_state != S_IDLE;
    assign o_strobe       = r_strobe;
    assign o_digit        = r_digit;
    assign o_cycle_length = r_olen;
    assign o_cycle_start  = r_ostart;
    assign o_digit_valid  = r_dvalid;
    assign o_is_last      = r_last;
    assign o_error        = r_error;

`ifndef SYNTHESIS
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("digit unit finished outside division state");

    a_cycle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_digit_valid |-> o_cycle_length != '0 && o_digit <= 4'd9
                                      && !o_error)
        else $error("bad cycle digit word");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error |-> o_is_last && !o_digit_valid)
        else $error("bad error word");
`endif

endmodule

// File: rtl/core/rdcf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcf_div
// Decimal digit unit: (rem*10)/den and (rem*10)%den in two radix-4 steps.
// ----------------------------------------------------------------------------
module rdcf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rdcf_pkg::REM_W-1:0]    i_rem,
    input  logic [rdcf_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [rdcf_pkg::DIG_W-1:0]    o_digit,
    output logic [rdcf_pkg::REM_W-1:0]    o_rem
);

    logic                          r_act;
    logic                          r_hi;
    logic [rdcf_pkg::CW-1:0]       r_part;
    logic [rdcf_pkg::DEN_W-1:0]    r_den;
    logic [rdcf_pkg::QW-1:0]       r_qhi;

    logic [rdcf_pkg::CW-1:0]       d1;
    logic [rdcf_pkg::CW-1:0]       d2;
    logic [rdcf_pkg::CW-1:0]       d3;
    logic [rdcf_pkg::CW-1:0]       sub;
    logic [rdcf_pkg::QW-1:0]       q;
    logic [rdcf_pkg::CW-1:0]       n_part;
    logic [rdcf_pkg::XW-1:0]       x;

    always_comb begin
        x  = rdcf_pkg::XW'(i_rem) * rdcf_pkg::XW'(rdcf_pkg::BASE);
        d1 = rdcf_pkg::CW'(r_den);
        d2 = d1 << 1;
        d3 = d1 + d2;
        if (r_hi) begin
            d1 = d1 << 2;
            d2 = d2 << 2;
            d3 = d3 << 2;
        end
        if (r_part >= d3) begin
            q   = 2'd3;
            sub = d3;
        end else if (r_part >= d2) begin
            q   = 2'd2;
            sub = d2;
        end else if (r_part >= d1) begin
            q   = 2'd1;
            sub = d1;
        end else begin
            q   = 2'd0;
            sub = '0;
        end
        n_part = r_part - sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_hi  <= 1'b0;
        end else if (i_start) begin
            r_act <= 1'b1;
            r_hi  <= 1'b1;
        end else if (r_act && r_hi) begin
            r_hi  <= 1'b0;
        end else if (r_act) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_part <= rdcf_pkg::CW'(x);
            r_den  <= i_den;
        end else if (r_act && r_hi) begin
            r_part <= n_part;
            r_qhi  <= q;
        end
    end

    assign o_done  = r_act && !r_hi;
    assign o_digit = {r_qhi, q};
    assign o_rem   = n_part[rdcf_pkg::REM_W-1:0];

endmodule

// File: rtl/core/rdcf_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcf_table
// Seen-remainder table (valid flags plus first position memory) and digit
// memory. Position and digit reads are registered; seen is combinational.
// ----------------------------------------------------------------------------
module rdcf_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rdcf_pkg::t_tbl_req            i_req,
    output logic                          o_seen,
    output logic [rdcf_pkg::POS_W-1:0]    o_pos_rdata,
    output logic [rdcf_pkg::DIG_W-1:0]    o_dig_rdata
);

    logic [rdcf_pkg::MAX_DENOMINATOR-1:0] r_valid;
    logic [rdcf_pkg::POS_W-1:0]           pos_mem [rdcf_pkg::MAX_DENOMINATOR];
    logic [rdcf_pkg::DIG_W-1:0]           dig_mem [rdcf_pkg::MAX_DENOMINATOR];
    logic [rdcf_pkg::POS_W-1:0]           r_pos_rd;
    logic [rdcf_pkg::DIG_W-1:0]           r_dig_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.pos_we) begin
            r_valid[i_req.rem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pos_we) begin
            pos_mem[i_req.rem_addr] <= i_req.pos_wdata;
        end
        r_pos_rd <= pos_mem[i_req.rem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.dig_we) begin
            dig_mem[i_req.dig_waddr] <= i_req.dig_wdata;
        end
        r_dig_rd <= dig_mem[i_req.dig_raddr];
    end

    assign o_seen      = r_valid[i_req.rem_addr];
    assign o_pos_rdata = r_pos_rd;
    assign o_dig_rdata = r_dig_rd;

`ifndef SYNTHESIS
    a_no_rewrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pos_we |-> !r_valid[i_req.rem_addr])
        else $error("remainder entry written twice");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clear |=> $countones(r_valid) == 0)
        else $error("seen flags not cleared");
`endif

endmodule
